// ===== rtl/ssq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants for the sorted sleep queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_POPPED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                  kind;
        logic [ID_WIDTH-1:0]   thread_id;
        logic [TIME_WIDTH-1:0] wake_time;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            status;
        logic [ID_WIDTH-1:0]   popped_thread;
        logic [TIME_WIDTH-1:0] popped_time;
        logic [OCC_W-1:0]      occupancy;
    } t_out_word;

    // broadcast from the control to every cell
    typedef struct packed {
        logic                  shift_in;
        logic                  shift_out;
        logic [ID_WIDTH-1:0]   new_id;
        logic [TIME_WIDTH-1:0] new_time;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/ssq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the queue: holds an entry, compares it with the key being
// inserted, and shifts toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module ssq_cell (
    input  wire logic                            i_clk,
    input  wire ssq_pkg::t_cell_ctl              i_ctl,
    input  wire logic                            i_occupied,
    input  wire logic                            i_left_keep,
    input  wire logic [ssq_pkg::ID_WIDTH-1:0]    i_left_id,
    input  wire logic [ssq_pkg::TIME_WIDTH-1:0]  i_left_time,
    input  wire logic [ssq_pkg::ID_WIDTH-1:0]    i_right_id,
    input  wire logic [ssq_pkg::TIME_WIDTH-1:0]  i_right_time,
    output logic                                 o_keep,
    output logic [ssq_pkg::ID_WIDTH-1:0]         o_id,
    output logic [ssq_pkg::TIME_WIDTH-1:0]       o_time
);
    import ssq_pkg::*;

    logic [ID_WIDTH-1:0]   r_id;
    logic [TIME_WIDTH-1:0] r_time;
    logic [ID_WIDTH-1:0]   n_id;
    logic [TIME_WIDTH-1:0] n_time;

    assign o_keep = i_occupied && (r_time <= i_ctl.new_time);
    assign o_id   = r_id;
    assign o_time = r_time;

    always_comb begin
        n_id   = r_id;
        n_time = r_time;
        if (i_ctl.shift_in && !o_keep) begin
            if (i_left_keep) begin
                n_id   = i_ctl.new_id;
                n_time = i_ctl.new_time;
            end else begin
                n_id   = i_left_id;
                n_time = i_left_time;
            end
        end else if (i_ctl.shift_out) begin
            n_id   = i_right_id;
            n_time = i_right_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_time <= n_time;
    end

endmodule
`default_nettype wire

// ===== rtl/sorted_sleep_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_sleep_queue
// Sleep queue of (thread id, wake time) entries kept in ascending wake time.
//
// Input channel i_in_*: a word is taken when i_in_valid is high and
// o_in_stall is low. kind selects insert or pop of the head entry.
// Output channel o_out_*: exactly one result word per input word, in order,
// held until i_out_stall is low with o_out_valid high.
// Storage is a row of QUEUE_DEPTH cells; every cell compares its key with
// the new key at once and shifts one place. The result is registered in
// the cycle after the word is taken; one word per cycle is taken while
// o_in_stall is low. The output register is the only buffer: while a result
// waits under i_out_stall, o_in_stall is raised.
// Equal wake times leave in arrival order. Insert into a full queue gives
// status full, pop of an empty queue gives status empty with zero payload.
// Reset (i_rst_n low, synchronous) empties the queue and clears the output
// valid; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_sleep_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ssq_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ssq_pkg::t_out_word      o_out_word
);
    import ssq_pkg::*;

    logic                  r_out_valid;
    t_out_word             r_out_word;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    t_out_word             n_out_word;
    logic                  w_take;
    logic                  w_full;
    logic                  w_empty;
    t_cell_ctl             w_ctl;

    logic [QUEUE_DEPTH-1:0] w_keep;
    logic [QUEUE_DEPTH-1:0] w_occ;
    logic [ID_WIDTH-1:0]    w_id   [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0]  w_time [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_order_ok;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_take      = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        w_ctl.shift_in  = w_take && (i_in_word.kind == KIND_INSERT) && !w_full;
        w_ctl.shift_out = w_take && (i_in_word.kind == KIND_POP) && !w_empty;
        w_ctl.new_id    = i_in_word.thread_id;
        w_ctl.new_time  = i_in_word.wake_time;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                  w_lkeep;
        logic [ID_WIDTH-1:0]   w_lid;
        logic [TIME_WIDTH-1:0] w_ltime;
        logic [ID_WIDTH-1:0]   w_rid;
        logic [TIME_WIDTH-1:0] w_rtime;

        assign w_occ[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_lkeep = 1'b1;
            assign w_lid   = w_id[0];
            assign w_ltime = w_time[0];
        end else begin : g_body
            assign w_lkeep = w_keep[g-1];
            assign w_lid   = w_id[g-1];
            assign w_ltime = w_time[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_rid   = w_id[g];
            assign w_rtime = w_time[g];
            assign w_order_ok[g] = 1'b1;
        end else begin : g_mid
            assign w_rid   = w_id[g+1];
            assign w_rtime = w_time[g+1];
            assign w_order_ok[g] = !w_occ[g+1] || (w_time[g] <= w_time[g+1]);
        end

        ssq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occupied   (w_occ[g]),
            .i_left_keep  (w_lkeep),
            .i_left_id    (w_lid),
            .i_left_time  (w_ltime),
            .i_right_id   (w_rid),
            .i_right_time (w_rtime),
            .o_keep       (w_keep[g]),
            .o_id         (w_id[g]),
            .o_time       (w_time[g])
        );
    end

    always_comb begin
        n_count                  = r_count;
        n_out_word.status        = ST_INSERTED;
        n_out_word.popped_thread = '0;
        n_out_word.popped_time   = '0;
        if (i_in_word.kind == KIND_INSERT) begin
            if (w_full) begin
                n_out_word.status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_out_word.status = ST_EMPTY;
            end else begin
                n_out_word.status        = ST_POPPED;
                n_out_word.popped_thread = w_id[0];
                n_out_word.popped_time   = w_time[0];
                n_count                  = r_count - CNT_W'(1);
            end
        end
        n_out_word.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_word <= n_out_word;
        end
    end

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_order_ok)
        else $error("held entries out of order");

    a_pop_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_in_word.kind == KIND_POP && !w_empty) |=>
        (r_out_word.status == ST_POPPED && r_out_word.popped_time == $past(w_time[0])
         && r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not return the head");

    a_insert_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_in_word.kind == KIND_INSERT && !w_full) |=>
        (r_count == $past(r_count) + CNT_W'(1) && r_out_word.status == ST_INSERTED))
        else $error("insert did not grow the queue");

endmodule
`default_nettype wire
